// ===== rtl/core/cidr_al_pkg.sv =====
// Shared types, constants and the prefix mask function of the CIDR allow list.
package cidr_al_pkg;

    // Table sizing
    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int PLEN_W  = 6;
    localparam int OCNT_W  = 5;

    // Prefix length limit
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_PREFIX = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_length;
    } t_req;

    typedef struct packed {
        logic              allowed;
        logic [1:0]        error_code;
        logic [OCNT_W-1:0] entry_count;
        logic              allow_all_present;
    } t_rsp;

    // Build the network mask: zero length or a length over 32 gives no bits
    function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        if (plen == '0 || plen > PLEN_MAX) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (PLEN_MAX - plen);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/ipv4_cidr_allow_list_core.sv =====
// Top level of the IPv4 CIDR allow list: entry table, parallel match and result register.
// Pipeline: a request is registered in r_in on acceptance, and its response is registered in
// r_out once the result register is free or draining; a stalled output holds it in r_in.
// Throughput: one request per cycle while the output is not stalled; all table entries are compared in parallel.
// Reset: synchronous, active low; clears the entry count and both valid flags.
// Table contents are not reset; entries past the count are never looked at.
module ipv4_cidr_allow_list_core
    import cidr_al_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    logic                 r_in_valid;
    t_req                 r_in;
    logic                 r_out_valid;
    t_rsp                 r_out;
    logic [CNT_W-1:0]     r_count;
    logic [ADDR_W-1:0]    r_net  [MAX_ENTRIES];
    logic [PLEN_W-1:0]    r_plen [MAX_ENTRIES];

    logic                 move;
    logic                 is_full;
    logic                 do_write;
    logic [IDX_W-1:0]     wr_idx;
    logic [ADDR_W-1:0]    wr_net;
    logic [CNT_W-1:0]     n_count;
    t_rsp                 n_out;
    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] zero_len;

    // Advance the request into the result stage when that stage is free or draining
    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;

    assign is_full  = (r_count >= CNT_W'(MAX_ENTRIES));
    assign do_write = (r_in.command == CMD_ADD) && !is_full
                      && (r_in.prefix_length <= PLEN_MAX);
    assign wr_idx   = r_count[IDX_W-1:0];
    assign wr_net   = r_in.address & mask_of(r_in.prefix_length);

    // Next entry count
    always_comb begin
        unique case (r_in.command)
            CMD_CLEAR: n_count = '0;
            CMD_ADD:   n_count = do_write ? r_count + CNT_W'(1) : r_count;
            default:   n_count = r_count;
        endcase
    end

    // Compare every live entry against the client address; flag zero-length entries
    always_comb begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            hit[k] = (CNT_W'(k) < r_count)
                     && ((r_in.address & mask_of(r_plen[k])) == r_net[k]);
            if (do_write && IDX_W'(k) == wr_idx) begin
                zero_len[k] = (CNT_W'(k) < n_count) && (r_in.prefix_length == '0);
            end else begin
                zero_len[k] = (CNT_W'(k) < n_count) && (r_plen[k] == '0);
            end
        end
    end

    // Form the response
    always_comb begin
        n_out.allowed           = (r_in.command == CMD_CHECK)
                                  && ((r_count == '0) || (|hit));
        n_out.error_code        = ERR_OK;
        if (r_in.command == CMD_ADD) begin
            priority if (is_full) begin
                n_out.error_code = ERR_FULL;
            end else if (r_in.prefix_length > PLEN_MAX) begin
                n_out.error_code = ERR_PREFIX;
            end else begin
                n_out.error_code = ERR_OK;
            end
        end
        n_out.entry_count       = OCNT_W'(n_count);
        n_out.allow_all_present = |zero_len;
    end

    // Hold the request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    // Register the response and update the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    // Store a new entry
    always_ff @(posedge i_clk) begin
        if (move && do_write) begin
            r_net[wr_idx]  <= wr_net;
            r_plen[wr_idx] <= r_in.prefix_length;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Checks
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_in.command == CMD_CLEAR |=> r_count == '0)
        else $error("clear did not empty the table");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_in.command == CMD_ADD && !do_write |=> r_count == $past(r_count))
        else $error("rejected add changed the entry count");

    a_empty_allows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_in.command == CMD_CHECK && r_count == '0 |=> o_out_rsp.allowed)
        else $error("check on empty table not allowed");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.entry_count == OCNT_W'(r_count))
        else $error("reported entry count differs from table count");

endmodule

// ===== tb/ipv4_cidr_allow_list_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 CIDR allow list core with its own table model.
module ipv4_cidr_allow_list_core_tb
    import cidr_al_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE   = 310;
    localparam int HOLD_CYCLES        = 60;
    localparam int DRAIN_CYCLES       = 10;
    localparam int CYCLE_LIMIT        = 200000;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_req i_in_req    = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_rsp;

    // Typed expectation that travels with the request on the wire
    bit   req_typed     = 1'b0;
    t_rsp req_typed_rsp = '0;

    // Model of the allow list table
    logic [ADDR_W-1:0] acl_net [MAX_ENTRIES];
    logic [PLEN_W-1:0] acl_len [MAX_ENTRIES];
    int                acl_count = 0;

    t_rsp      pending_rsp [$];
    t_stim_row dir_rows [$];
    int        phase         = 0;
    bit        pressure_req  = 1'b0;
    int        error_count   = 0;
    int        cycle_count   = 0;

    ipv4_cidr_allow_list_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Top prefix bits set; zero length and illegal lengths give no bits
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        if (len == '0 || len > PLEN_MAX) begin
            return '0;
        end
        return {ADDR_W{1'b1}} << (PLEN_MAX - len);
    endfunction

    // Apply one request to the table model and return its response
    function automatic t_rsp lookup_and_update(input t_req r);
        t_rsp rsp;
        int   k;
        rsp = '0;
        case (r.command)
            CMD_CLEAR: begin
                acl_count = 0;
            end
            CMD_ADD: begin
                if (acl_count >= MAX_ENTRIES) begin
                    rsp.error_code = ERR_FULL;
                end else if (r.prefix_length > PLEN_MAX) begin
                    rsp.error_code = ERR_PREFIX;
                end else begin
                    acl_net[acl_count] = r.address & prefix_mask(r.prefix_length);
                    acl_len[acl_count] = r.prefix_length;
                    acl_count++;
                end
            end
            CMD_CHECK: begin
                if (acl_count == 0) begin
                    rsp.allowed = 1'b1;
                end
                for (k = 0; k < acl_count; k++) begin
                    if ((r.address & prefix_mask(acl_len[k])) == acl_net[k]) begin
                        rsp.allowed = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rsp.entry_count = OCNT_W'(acl_count);
        for (k = 0; k < acl_count; k++) begin
            if (acl_len[k] == '0) begin
                rsp.allow_all_present = 1'b1;
            end
        end
        return rsp;
    endfunction

    // Mostly adds and checks; checks often aim at a stored entry or just miss it
    function automatic t_req random_request();
        t_req              r;
        int                roll;
        int                clear_pct;
        int                k;
        int                sel;
        logic [ADDR_W-1:0] m;
        r.address       = $urandom;
        r.prefix_length = PLEN_W'($urandom);
        clear_pct       = (acl_count >= MAX_ENTRIES) ? 8 : 1;
        roll            = $urandom_range(99);
        if (roll < clear_pct) begin
            r.command = CMD_CLEAR;
        end else if (roll < clear_pct + 3) begin
            r.command = CMD_UNUSED;
        end else if (roll < 42) begin
            r.command = CMD_ADD;
            sel = $urandom_range(99);
            if (sel < 3) begin
                r.prefix_length = '0;
            end else if (sel < 85) begin
                r.prefix_length = PLEN_W'($urandom_range(32, 1));
            end else begin
                r.prefix_length = PLEN_W'($urandom_range(63, 33));
            end
        end else begin
            r.command = CMD_CHECK;
            if (acl_count > 0 && $urandom_range(9) < 7) begin
                k = $urandom_range(acl_count - 1);
                m = prefix_mask(acl_len[k]);
                r.address = acl_net[k] | (r.address & ~m);
                // Flip one network bit for a near miss
                if (acl_len[k] != '0 && $urandom_range(4) == 0) begin
                    sel = 32 - acl_len[k] + $urandom_range(acl_len[k] - 1);
                    r.address[sel] = ~r.address[sel];
                end
            end
        end
        return r;
    endfunction

    function automatic void push_row(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                                     input logic [PLEN_W-1:0] len, input bit typed,
                                     input t_rsp rsp);
        t_stim_row row;
        row.req   = '{command: cmd, address: addr, prefix_length: len};
        row.typed = typed;
        row.rsp   = rsp;
        dir_rows.push_back(row);
    endfunction

    function automatic int sender_idle_pct();
        case (phase)
            0:       return 36;
            1:       return 81;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (phase)
            0:       return 81;
            1:       return 36;
            default: return 0;
        endcase
    endfunction

    // Offer one request at the falling edge and hold it until accepted
    task automatic send_request(input t_req r, input bit typed, input t_rsp rsp);
        while ($urandom_range(99) < sender_idle_pct()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_req      <= r;
        req_typed     <= typed;
        req_typed_rsp <= rsp;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Reset, directed table, random phases, drain
    initial begin
        int k;
        int p;
        int n;
        push_row(CMD_CHECK, 32'h1234_5678, 6'd0, 1'b1,
                 '{allowed: 1'b1, error_code: ERR_OK, entry_count: 5'd0,
                   allow_all_present: 1'b0});
        push_row(CMD_ADD, 32'hdead_beef, 6'd63, 1'b1,
                 '{allowed: 1'b0, error_code: ERR_PREFIX, entry_count: 5'd0,
                   allow_all_present: 1'b0});
        push_row(CMD_ADD, 32'hffff_ffff, 6'd32, 1'b1,
                 '{allowed: 1'b0, error_code: ERR_OK, entry_count: 5'd1,
                   allow_all_present: 1'b0});
        push_row(CMD_CHECK, 32'hffff_ffff, 6'd0, 1'b0, '0);
        push_row(CMD_CHECK, 32'h0000_0000, 6'd63, 1'b0, '0);
        push_row(CMD_UNUSED, 32'hffff_ffff, 6'd63, 1'b1,
                 '{allowed: 1'b0, error_code: ERR_OK, entry_count: 5'd1,
                   allow_all_present: 1'b0});
        push_row(CMD_CLEAR, 32'h0000_0000, 6'd0, 1'b1,
                 '{allowed: 1'b0, error_code: ERR_OK, entry_count: 5'd0,
                   allow_all_present: 1'b0});
        // Fill the table, one allow-all entry among them
        for (k = 0; k < MAX_ENTRIES; k++) begin
            push_row(CMD_ADD, (32'h0a00_0000 ^ (k << 24)) ^ (k * 32'h0001_3579),
                     (k == 7) ? 6'd0 : PLEN_W'(17 + k), 1'b0, '0);
        end
        // Full table and bad length together: the full error wins
        push_row(CMD_ADD, 32'hffff_ffff, 6'd33, 1'b1,
                 '{allowed: 1'b0, error_code: ERR_FULL, entry_count: 5'd16,
                   allow_all_present: 1'b1});
        push_row(CMD_CHECK, 32'h0000_0000, 6'd0, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < dir_rows.size(); n++) begin
            send_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp);
        end
        for (p = 0; p < 3; p++) begin
            phase = p;
            if (p == 2) begin
                pressure_req = 1'b1;
            end
            repeat (RANDOM_PER_PHASE) begin
                send_request(random_request(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ipv4_cidr_allow_list_core_tb OK");
        end else begin
            $display("ipv4_cidr_allow_list_core_tb NOT OK");
        end
        $finish;
    end

    // Drive the response ready; once, hold it off long enough to back up the core
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // Predict on each accepted request, check each accepted response
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = lookup_and_update(i_in_req);
                if (req_typed) begin
                    want = req_typed_rsp;
                end
                pending_rsp.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_rsp.size() == 0) begin
                    error_count++;
                    $display("%0t: response with no request outstanding, got %p",
                             $time, o_out_rsp);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_out_rsp.allowed !== want.allowed) begin
                        error_count++;
                        $display("%0t: allowed expected %0d got %0d",
                                 $time, want.allowed, o_out_rsp.allowed);
                    end
                    if (o_out_rsp.error_code !== want.error_code) begin
                        error_count++;
                        $display("%0t: error_code expected %0d got %0d",
                                 $time, want.error_code, o_out_rsp.error_code);
                    end
                    if (o_out_rsp.entry_count !== want.entry_count) begin
                        error_count++;
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, want.entry_count, o_out_rsp.entry_count);
                    end
                    if (o_out_rsp.allow_all_present !== want.allow_all_present) begin
                        error_count++;
                        $display("%0t: allow_all_present expected %0d got %0d",
                                 $time, want.allow_all_present, o_out_rsp.allow_all_present);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ipv4_cidr_allow_list_core_tb NOT OK");
            $finish;
        end
    end

endmodule

// ===== ipv4_cidr_allow_list_core.f =====
rtl/core/cidr_al_pkg.sv
rtl/core/ipv4_cidr_allow_list_core.sv
tb/ipv4_cidr_allow_list_core_tb.sv
